// ===== rtl/ms_pkg.sv =====
// Package with the shared types and codes of the minimum stack.
`default_nettype none

package ms_pkg;

  localparam int unsigned DEPTH = 128;
  localparam int unsigned WORD_W = 32;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP = 2'd1;
  localparam logic [1:0] CMD_MIN = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic signed [WORD_W-1:0] minimum;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

`default_nettype wire

// ===== rtl/min_stack.sv =====
// Top level of the minimum stack: command head, cell chain and result register.
//
// The block takes one request per cycle on the input channel (in_valid_i,
// in_stall_o) with a command and a word. A push stores the word on top, a pop
// returns the top word and a minimum query returns the smallest stored word.
// Refused requests return zero with an overflow, underflow or empty status.
// Every request gives exactly one result on the output channel (out_valid_o,
// out_stall_i), in the cycle after the request is taken.
// The words sit in a chain of DEPTH cells that shift down on a push and up on
// a pop. Each cell keeps the minimum of its word and all words below it, so
// the top cell always holds the current minimum and no search is needed.
// Throughput is one request per cycle while in_stall_o is low; the result is
// held in the result register.
// While a result waits under out_valid_o and out_stall_i is high, in_stall_o
// is high and no request is taken; otherwise a new request is taken in the
// same cycle that the old result leaves.
// Reset empties the stack at once; the cell contents are not cleared.
`default_nettype none

module min_stack #(
  parameter int unsigned DEPTH = ms_pkg::DEPTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [1:0]                       cmd_i,
  input  wire logic signed [ms_pkg::WORD_W-1:0] push_value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic signed [ms_pkg::WORD_W-1:0]      result_value_o,
  output logic [1:0]                            status_o
);

  logic                              accept;
  ms_pkg::entry_t                    new_entry;
  ms_pkg::shift_t                    shift;
  ms_pkg::entry_t                    cells [DEPTH];
  logic signed [ms_pkg::WORD_W-1:0]  result_value_d;
  logic signed [ms_pkg::WORD_W-1:0]  result_value_q;
  logic [1:0]                        status_d;
  logic [1:0]                        status_q;
  logic                              out_valid_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept = in_valid_i && !in_stall_o;

  ms_head #(
    .DEPTH(DEPTH)
  ) u_head (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .cmd_i          (cmd_i),
    .push_value_i   (push_value_i),
    .top_i          (cells[0]),
    .new_entry_o    (new_entry),
    .shift_o        (shift),
    .result_value_o (result_value_d),
    .status_o       (status_d)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ms_pkg::entry_t above;
    ms_pkg::entry_t below;

    if (i == 0) begin : g_top
      assign above = new_entry;
    end else begin : g_inner
      assign above = cells[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign below = cells[i];
    end else begin : g_upper
      assign below = cells[i+1];
    end

    ms_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .above_i (above),
      .below_i (below),
      .entry_o (cells[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_value_q <= result_value_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_value_o = result_value_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

// ===== rtl/ms_cell.sv =====
// One stack cell holding a word and the minimum of itself and all cells below it.
`default_nettype none

module ms_cell (
  input  wire logic           clk_i,
  input  wire ms_pkg::shift_t shift_i,
  input  wire ms_pkg::entry_t above_i,
  input  wire ms_pkg::entry_t below_i,
  output ms_pkg::entry_t      entry_o
);

  ms_pkg::entry_t entry_q;
  ms_pkg::entry_t entry_d;

  always_comb begin
    entry_d = entry_q;
    if (shift_i.push) begin
      entry_d = above_i;
    end else if (shift_i.pop) begin
      entry_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== rtl/ms_head.sv =====
// Command decoder and fill counter that feed the top of the cell chain.
`default_nettype none

module ms_head #(
  parameter int unsigned DEPTH = ms_pkg::DEPTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             accept_i,
  input  wire logic [1:0]                       cmd_i,
  input  wire logic signed [ms_pkg::WORD_W-1:0] push_value_i,
  input  wire ms_pkg::entry_t                   top_i,
  output ms_pkg::entry_t                        new_entry_o,
  output ms_pkg::shift_t                        shift_o,
  output logic signed [ms_pkg::WORD_W-1:0]      result_value_o,
  output logic [1:0]                            status_o
);

  localparam int unsigned CountW = $clog2(DEPTH + 1);

  logic [CountW-1:0] count_q;
  logic [CountW-1:0] count_d;
  logic              full;
  logic              empty;

  assign full = (count_q == CountW'(DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    new_entry_o.value = push_value_i;
    if (empty || ($signed(push_value_i) < $signed(top_i.minimum))) begin
      new_entry_o.minimum = push_value_i;
    end else begin
      new_entry_o.minimum = top_i.minimum;
    end
  end

  always_comb begin
    shift_o = '0;
    result_value_o = '0;
    status_o = ms_pkg::ST_OK;
    count_d = count_q;
    unique case (cmd_i)
      ms_pkg::CMD_PUSH: begin
        if (full) begin
          status_o = ms_pkg::ST_OVERFLOW;
        end else begin
          shift_o.push = accept_i;
          if (accept_i) begin
            count_d = count_q + CountW'(1);
          end
        end
      end
      ms_pkg::CMD_POP: begin
        if (empty) begin
          status_o = ms_pkg::ST_UNDERFLOW;
        end else begin
          result_value_o = top_i.value;
          shift_o.pop = accept_i;
          if (accept_i) begin
            count_d = count_q - CountW'(1);
          end
        end
      end
      ms_pkg::CMD_MIN: begin
        if (empty) begin
          status_o = ms_pkg::ST_EMPTY;
        end else begin
          result_value_o = top_i.minimum;
        end
      end
      default: begin
        status_o = ms_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ms_checker.sv =====
// Port checker of the minimum stack and the bind that attaches it to the top level.
`default_nettype none

module ms_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_stall_o,
  input wire logic [1:0]                       cmd_i,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic signed [ms_pkg::WORD_W-1:0] result_value_o,
  input wire logic [1:0]                       status_o
);

  logic in_take;

  assign in_take = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(result_value_o) && $stable(status_o))
    else $error("Result changed while stalled.");

  a_push_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && cmd_i == ms_pkg::CMD_PUSH |=> out_valid_o && result_value_o == '0
      && (status_o == ms_pkg::ST_OK || status_o == ms_pkg::ST_OVERFLOW))
    else $error("Push request gave a wrong result.");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && cmd_i == ms_pkg::CMD_POP |=> out_valid_o
      && (status_o == ms_pkg::ST_OK || status_o == ms_pkg::ST_UNDERFLOW))
    else $error("Pop request gave a wrong status.");

  a_min_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && cmd_i == ms_pkg::CMD_MIN |=> out_valid_o
      && (status_o == ms_pkg::ST_OK || status_o == ms_pkg::ST_EMPTY))
    else $error("Minimum request gave a wrong status.");

endmodule

bind min_stack ms_checker u_ms_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .cmd_i          (cmd_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .result_value_o (result_value_o),
  .status_o       (status_o)
);

`default_nettype wire
